/* rtl/scfl_pkg.sv */
package scfl_pkg;

    // Widths fixed by the item fields.
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned INDEX_W = 4;

    typedef enum logic [1:0] {
        ST_GRANT      = 2'd0,
        ST_FALLBACK   = 2'd1,
        ST_FREED_POOL = 2'd2,
        ST_FREED_OUT  = 2'd3
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [SIZE_W-1:0]   request_size;
        logic                from_pool;
        logic [CLASS_W-1:0]  free_class;
        logic [INDEX_W-1:0]  free_index;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [CLASS_W-1:0]  block_class;
        logic [INDEX_W-1:0]  block_index;
    } t_rsp;

    // Result of mapping a byte count to a size class.
    typedef struct packed {
        logic                oversize;
        logic [CLASS_W-1:0]  cls;
    } t_class_sel;

endpackage

/* rtl/scfl_class_map.sv */
module scfl_class_map #(
    parameter int NUM_CLASSES     = 5,
    parameter int MIN_CLASS_SHIFT = 6
) (
    input  logic [scfl_pkg::SIZE_W-1:0] i_size,
    output scfl_pkg::t_class_sel        o_sel
);
    import scfl_pkg::*;

    localparam logic [31:0] MAX_SIZE = 32'd1 << (MIN_CLASS_SHIFT + NUM_CLASSES - 1);

    logic [31:0]        size_ext;
    logic [CLASS_W-1:0] cnt;

    assign size_ext = {{(32-SIZE_W){1'b0}}, i_size};

    // The class thresholds rise monotonically, so the class number is the
    // count of thresholds that the size exceeds, capped at the last class.
    always_comb begin
        cnt = '0;
        for (int c = 0; c < NUM_CLASSES - 1; c++) begin
            if (size_ext > (32'd1 << (MIN_CLASS_SHIFT + c))) begin
                cnt = cnt + CLASS_W'(1);
            end
        end
    end

    assign o_sel.oversize = (size_ext > MAX_SIZE);
    assign o_sel.cls      = cnt;

endmodule

/* rtl/size_class_free_list_allocator.sv */
// A taken start beat enters the execute state, whose result is registered onto
// o_done. Busy holds off a new item until the last one is through; the link
// memory's registered read sits between taking an item and the class head update.
// Reset (synchronous, active low) chains every class list in index order and
// clears the pending item; no clearing pass, start is taken right after reset.
// Results cannot be stalled: o_done is high for exactly one cycle per item.
module size_class_free_list_allocator #(
    parameter int BLOCKS_PER_CLASS = 16,
    parameter int NUM_CLASSES      = 5,
    parameter int MIN_CLASS_SHIFT  = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  scfl_pkg::t_req  i_req,
    output logic            o_done,
    output scfl_pkg::t_rsp  o_rsp
);
    import scfl_pkg::*;

    localparam int TOTAL_BLOCKS = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int ADDR_W       = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int LINK_W       = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int CIDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLOCKS_PER_CLASS);

    // Link memory and its per-entry valid bits; an entry not yet written
    // reads as its reset chain value.
    logic [LINK_W-1:0] r_link_mem [TOTAL_BLOCKS];
    logic [TOTAL_BLOCKS-1:0] r_link_vld;
    logic [LINK_W-1:0] r_rd_data;

    logic [LINK_W-1:0] r_class_head [NUM_CLASSES];

    t_state            r_state, n_state;
    t_req              r_req;
    t_class_sel        r_sel;
    logic [LINK_W-1:0] r_head;
    logic [ADDR_W-1:0] r_addr;
    logic              r_free_ok;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    t_class_sel        map_sel;
    logic              accept;
    logic [CLASS_W-1:0] sel_cls;
    logic [INDEX_W-1:0] sel_idx;
    logic [LINK_W-1:0] sel_head;
    logic [ADDR_W-1:0] sel_addr;
    logic              free_ok;
    logic              mem_wr;
    logic              head_wr;
    logic [LINK_W-1:0] head_wdata;
    logic [LINK_W-1:0] reset_link;
    logic [LINK_W-1:0] link_val;

    scfl_class_map #(
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_CLASS_SHIFT (MIN_CLASS_SHIFT)
    ) u_class_map (
        .i_size (i_req.request_size),
        .o_sel  (map_sel)
    );

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    // Beat-side selection: which class head and which link entry this item
    // touches. For an allocate the entry is the head's link, for a free it
    // is the returned block.
    assign free_ok = i_req.from_pool
                     && (32'(i_req.free_class) < 32'(NUM_CLASSES))
                     && (32'(i_req.free_index) < 32'(BLOCKS_PER_CLASS));

    always_comb begin
        if (i_req.action == ACT_ALLOC) begin
            sel_cls = map_sel.cls;
        end else begin
            sel_cls = free_ok ? i_req.free_class : '0;
        end
        sel_head = r_class_head[sel_cls[CIDX_W-1:0]];
        if (i_req.action == ACT_ALLOC) begin
            sel_idx = INDEX_W'(sel_head);
        end else begin
            sel_idx = i_req.free_index;
        end
        sel_addr = ADDR_W'(sel_cls) * ADDR_W'(BLOCKS_PER_CLASS) + ADDR_W'(sel_idx);
    end

    always_comb begin
        if (32'(r_head) + 32'd1 < 32'(BLOCKS_PER_CLASS)) begin
            reset_link = r_head + LINK_W'(1);
        end else begin
            reset_link = LINK_NULL;
        end
        link_val = r_link_vld[r_addr] ? r_rd_data : reset_link;
    end

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        mem_wr     = 1'b0;
        head_wr    = 1'b0;
        head_wdata = link_val;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_req.action == ACT_ALLOC) begin
                    if (r_sel.oversize) begin
                        n_rsp = '{ST_FALLBACK, '0, '0};
                    end else if (r_head >= LINK_NULL) begin
                        n_rsp = '{ST_FALLBACK, r_sel.cls, '0};
                    end else begin
                        head_wr    = 1'b1;
                        head_wdata = link_val;
                        n_rsp      = '{ST_GRANT, r_sel.cls, INDEX_W'(r_head)};
                    end
                end else begin
                    if (r_free_ok) begin
                        mem_wr     = 1'b1;
                        head_wr    = 1'b1;
                        head_wdata = LINK_W'(r_req.free_index);
                        n_rsp      = '{ST_FREED_POOL, r_req.free_class, '0};
                    end else begin
                        n_rsp = '{ST_FREED_OUT, '0, '0};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (accept) begin
            r_req     <= i_req;
            r_sel     <= map_sel;
            r_head    <= sel_head;
            r_addr    <= sel_addr;
            r_free_ok <= free_ok;
        end
    end

    // The free's write lands at the end of the execute cycle, before the
    // next item's read can be issued, so reads and writes never overlap.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_link_mem[r_addr] <= r_head;
        end
        if (accept) begin
            r_rd_data <= r_link_mem[sel_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (mem_wr) begin
            r_link_vld[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_class_head[c] <= '0;
            end
        end else if (head_wr) begin
            if (r_req.action == ACT_ALLOC) begin
                r_class_head[r_sel.cls[CIDX_W-1:0]] <= head_wdata;
            end else begin
                r_class_head[r_req.free_class[CIDX_W-1:0]] <= head_wdata;
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute state held longer than one cycle");

    a_done_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("execute cycle did not produce a result beat");

    a_done_needs_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a preceding execute cycle");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_GRANT) |->
            (32'(o_rsp.block_index) < 32'(BLOCKS_PER_CLASS)
             && 32'(o_rsp.block_class) < 32'(NUM_CLASSES)))
        else $error("granted block outside the pool");

    a_no_index_unless_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_GRANT) |-> (o_rsp.block_index == '0))
        else $error("block index set on a result that is not a grant");

endmodule
